// ===== hw/rtl/crc32br_pkg.sv =====
// Shared types and constants for the byte-serial reflected CRC-32 core.
// Holds reset values, register indexes and the configuration bundle.
// No dependencies.
package crc32br_pkg;

  localparam int unsigned CRC_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CRC_W-1:0] POLY_RESET  = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] START_RESET = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] MASK_RESET  = 32'hFFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLYNOMIAL  = 2'd0,
    REG_START_VALUE = 2'd1,
    REG_FINAL_MASK  = 2'd2
  } cfg_reg_t;

  // Configuration bundle handed to the datapath
  typedef struct packed {
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] start_value;
    logic [CRC_W-1:0] final_mask;
  } crc_cfg_t;

endpackage

// ===== hw/rtl/crc32br_cfg_regs.sv =====
// Configuration register file for the reflected CRC-32 core.
// Decodes plain index writes into polynomial, start value and final mask.
// Depends on crc32br_pkg.
module crc32br_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [crc32br_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crc32br_pkg::CRC_W-1:0]        cfg_wdata,
  output crc32br_pkg::crc_cfg_t                cfg
);
  import crc32br_pkg::*;

  crc_cfg_t cfg_r;
  crc_cfg_t cfg_nxt;

  // Decode the write; an index past the list leaves everything alone
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_POLYNOMIAL:  cfg_nxt.polynomial  = cfg_wdata;
        REG_START_VALUE: cfg_nxt.start_value = cfg_wdata;
        REG_FINAL_MASK:  cfg_nxt.final_mask  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polynomial  <= POLY_RESET;
      cfg_r.start_value <= START_RESET;
      cfg_r.final_mask  <= MASK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/crc32br_byte_update.sv =====
// Combinational byte update for the reflected CRC-32 core: optional reload,
// eight LSB-first shift/XOR steps, then final mask and 32-bit reversal.
// Depends on crc32br_pkg.
module crc32br_byte_update (
  input  logic [crc32br_pkg::CRC_W-1:0]  rem_cur,
  input  logic [crc32br_pkg::BYTE_W-1:0] data_byte,
  input  logic                           start_req,
  input  crc32br_pkg::crc_cfg_t          cfg,
  output logic [crc32br_pkg::CRC_W-1:0]  rem_new,
  output logic [crc32br_pkg::CRC_W-1:0]  crc_new
);
  import crc32br_pkg::*;

  logic [CRC_W-1:0] rem_work;
  logic [CRC_W-1:0] masked;

  // Reload on start, fold in the byte, then run the eight bit steps
  always_comb begin
    rem_work = start_req ? cfg.start_value : rem_cur;
    rem_work = rem_work ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
    for (int i = 0; i < BYTE_W; i++) begin
      if (rem_work[0]) begin
        rem_work = (rem_work >> 1) ^ cfg.polynomial;
      end else begin
        rem_work = rem_work >> 1;
      end
    end
  end

  assign rem_new = rem_work;
  assign masked  = rem_work ^ cfg.final_mask;

  // Reverse bit order over the full word
  always_comb begin
    for (int i = 0; i < CRC_W; i++) begin
      crc_new[i] = masked[CRC_W-1-i];
    end
  end

endmodule

// ===== hw/rtl/crc32_bytewise_reflected_core.sv =====
// Byte-serial reflected CRC-32 core: one word in, one finished CRC out, one
// word per clock sustained. The remainder update is a combinational eight-step
// XOR network from the input port into the remainder and result registers, so
// each word gives its result in the cycle after acceptance and a new word is
// taken every cycle while the result register is empty or being drained.
// A word with start_req set reloads the remainder from the start value first.
// Configuration writes take effect on the next word and belong in idle time.
// Depends on crc32br_pkg, crc32br_cfg_regs and crc32br_byte_update.
module crc32_bytewise_reflected_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [crc32br_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crc32br_pkg::CRC_W-1:0]        cfg_wdata,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [crc32br_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                                 in_start_req,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [crc32br_pkg::CRC_W-1:0]        out_crc_value
);
  import crc32br_pkg::*;

  crc_cfg_t         cfg;
  logic [CRC_W-1:0] remainder_r;
  logic [CRC_W-1:0] remainder_nxt;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic             out_valid_r;
  logic             in_fire;

  crc32br_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  crc32br_byte_update u_byte_update (
    .rem_cur   (remainder_r),
    .data_byte (in_data_byte),
    .start_req (in_start_req),
    .cfg       (cfg),
    .rem_new   (remainder_nxt),
    .crc_new   (crc_nxt)
  );

  // Take a word whenever the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Advance the remainder on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remainder_r <= START_RESET;
    end else if (in_fire) begin
      remainder_r <= remainder_nxt;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      crc_r <= crc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = crc_r;

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_rem_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(remainder_r))
    else $error("remainder changed without an accepted word");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");
`endif

endmodule

// ===== verif/tb_crc32_bytewise_reflected_core.sv =====
// Self-checking testbench for crc32_bytewise_reflected_core: directed table
// plus random messages, each checked against a reflected CRC-32 predictor or known CRC.
// Depends on crc32br_pkg and the core RTL.
module tb_crc32_bytewise_reflected_core;
  import crc32br_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, writes dropped
  localparam int RAND_PHASES = 9;
  localparam int PHASE_WORDS = 150;
  localparam int MAX_REPORTS = 10;

  typedef enum {ROW_WORD, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CRC_W-1:0]     wdata;
    logic [BYTE_W-1:0]    data_byte;
    logic                 start_req;
    bit                   has_known;
    logic [CRC_W-1:0]     known_crc;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CRC_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_data_byte;
  logic                 in_start_req;
  logic                 out_valid;
  logic                 out_ready;
  logic [CRC_W-1:0]     out_crc_value;

  // Shadow of the core: configuration and running remainder
  logic [CRC_W-1:0] crc_poly;
  logic [CRC_W-1:0] crc_seed;
  logic [CRC_W-1:0] crc_xorout;
  logic [CRC_W-1:0] crc_rem;

  logic [CRC_W-1:0] crc_expq[$];
  stim_row_t        dir_rows[$];
  int               err_count;
  bit               steady;

  crc32_bytewise_reflected_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_start_req (in_start_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_crc_value(out_crc_value)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Absorb one byte LSB first, eight shift/XOR steps
  function automatic logic [CRC_W-1:0] fold_byte(logic [CRC_W-1:0] rem,
                                                 logic [BYTE_W-1:0] b,
                                                 logic [CRC_W-1:0] poly);
    rem = rem ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (rem[0]) rem = (rem >> 1) ^ poly;
      else rem = rem >> 1;
    end
    return rem;
  endfunction

  function automatic logic [CRC_W-1:0] flip32(logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) r[i] = v[CRC_W-1-i];
    return r;
  endfunction

  // Advance the shadow remainder by one word and return the finished CRC
  function automatic logic [CRC_W-1:0] next_crc(logic [BYTE_W-1:0] b, logic start);
    if (start) crc_rem = crc_seed;
    crc_rem = fold_byte(crc_rem, b, crc_poly);
    return flip32(crc_rem ^ crc_xorout);
  endfunction

  function automatic stim_row_t word_row(logic [BYTE_W-1:0] b, logic start);
    stim_row_t r;
    r = '{ROW_WORD, '0, '0, b, start, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [BYTE_W-1:0] b, logic start,
                                          logic [CRC_W-1:0] crc);
    stim_row_t r;
    r = '{ROW_WORD, '0, '0, b, start, 1'b1, crc};
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CRC_W-1:0] v);
    stim_row_t r;
    r = '{ROW_WRITE, idx, v, '0, 1'b0, 1'b0, '0};
    return r;
  endfunction

  // Pick a register value: extremes, the reset value, or anything
  function automatic logic [CRC_W-1:0] pick_reg(logic [CRC_W-1:0] reset_val);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return reset_val;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(string what, logic [CRC_W-1:0] expv, logic [CRC_W-1:0] actv);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%s: expected %08h, got %08h", what, expv, actv);
  endtask

  // Write one register; the shadow follows the same decode
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CRC_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POLYNOMIAL:  crc_poly = v;
      REG_START_VALUE: crc_seed = v;
      REG_FINAL_MASK:  crc_xorout = v;
      default: ;
    endcase
  endtask

  // Hold until every word has come back, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    while (crc_expq.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Present one word at a falling edge; hold it until accepted
  task automatic send_word(logic [BYTE_W-1:0] b, logic start, bit has_known,
                           logic [CRC_W-1:0] known);
    logic [CRC_W-1:0] pred;
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_start_req <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = next_crc(b, start);
    crc_expq.push_back(has_known ? known : pred);
    @(negedge clk);
  endtask

  // Result side: random backpressure
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 6);
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (crc_expq.size() == 0) begin
        report_error("unexpected word", '0, out_crc_value);
      end else begin
        if (out_crc_value !== crc_expq[0])
          report_error("crc_value mismatch", crc_expq[0], out_crc_value);
        void'(crc_expq.pop_front());
      end
    end
  end

  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_start_req = 1'b0;
    out_ready    = 1'b0;
    err_count    = 0;
    steady       = 1'b0;
    crc_poly     = POLY_RESET;
    crc_seed     = START_RESET;
    crc_xorout   = MASK_RESET;
    crc_rem      = START_RESET;

    // Directed rows: reset config, the standard check string, then extremes
    dir_rows.push_back(word_row(8'h00, 1'b0));          // no start after reset
    dir_rows.push_back(word_row(8'hFF, 1'b0));
    dir_rows.push_back(word_row(8'h31, 1'b1));          // "123456789"
    dir_rows.push_back(word_row(8'h32, 1'b0));
    dir_rows.push_back(word_row(8'h33, 1'b0));
    dir_rows.push_back(word_row(8'h34, 1'b0));
    dir_rows.push_back(word_row(8'h35, 1'b0));
    dir_rows.push_back(word_row(8'h36, 1'b0));
    dir_rows.push_back(word_row(8'h37, 1'b0));
    dir_rows.push_back(word_row(8'h38, 1'b0));
    dir_rows.push_back(known_row(8'h39, 1'b0, 32'h649C_2FD3));
    // zero polynomial: the remainder just shifts right by a byte
    dir_rows.push_back(write_row(REG_POLYNOMIAL, 32'h0000_0000));
    dir_rows.push_back(write_row(REG_FINAL_MASK, 32'h0000_0000));
    dir_rows.push_back(known_row(8'hFF, 1'b1, 32'hFFFF_FF00));
    dir_rows.push_back(known_row(8'h00, 1'b0, 32'hFFFF_0000));
    // start value changed mid-message: only the next start picks it up
    dir_rows.push_back(write_row(REG_START_VALUE, 32'h0000_0000));
    dir_rows.push_back(word_row(8'hA5, 1'b0));
    dir_rows.push_back(write_row(REG_POLYNOMIAL, 32'hFFFF_FFFF));
    dir_rows.push_back(write_row(REG_FINAL_MASK, 32'hFFFF_FFFF));
    dir_rows.push_back(known_row(8'h00, 1'b1, 32'hFFFF_FFFF));
    dir_rows.push_back(word_row(8'h80, 1'b0));
    dir_rows.push_back(word_row(8'h01, 1'b0));
    // write to an unmapped index must leave every register alone
    dir_rows.push_back(write_row(REG_SPARE, 32'h1234_5678));
    dir_rows.push_back(word_row(8'h5A, 1'b0));
    dir_rows.push_back(word_row(8'hC3, 1'b1));
    dir_rows.push_back(write_row(REG_POLYNOMIAL, POLY_RESET));
    dir_rows.push_back(write_row(REG_START_VALUE, START_RESET));
    dir_rows.push_back(write_row(REG_FINAL_MASK, MASK_RESET));
    dir_rows.push_back(word_row(8'h7E, 1'b1));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
      end else begin
        send_word(dir_rows[i].data_byte, dir_rows[i].start_req,
                  dir_rows[i].has_known, dir_rows[i].known_crc);
      end
    end

    // Random messages under a new configuration each phase after the first
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      if (ph > 0) begin
        write_reg(REG_POLYNOMIAL, pick_reg(POLY_RESET));
        write_reg(REG_START_VALUE, pick_reg(START_RESET));
        write_reg(REG_FINAL_MASK, pick_reg(MASK_RESET));
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
      end
      steady = (ph == 3 || ph == 4);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain();
    repeat (5) @(negedge clk);
    if (crc_expq.size() != 0)
      report_error("words never returned", CRC_W'(crc_expq.size()), '0);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
